>>> rtl/core/sru_pkg.sv
// ============================================================================
// sru_pkg - shared types and helpers for the 8/16-bit shift and rotate unit
// Operation codes, beat structs and count-reduction functions.
// ============================================================================
package sru_pkg;

    // operation codes
    localparam logic [2:0] OP_ROL = 3'd0;
    localparam logic [2:0] OP_ROR = 3'd1;
    localparam logic [2:0] OP_RCL = 3'd2;
    localparam logic [2:0] OP_RCR = 3'd3;
    localparam logic [2:0] OP_SHL = 3'd4;
    localparam logic [2:0] OP_SHR = 3'd5;
    localparam logic [2:0] OP_SAR = 3'd6;

    localparam logic [4:0] CNT_MASK = 5'h1F;

    // default depth of the queue between decode and execute
    localparam int SRU_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]  mode;
        logic        byte_width;
        logic [15:0] value;
        logic [7:0]  shift_count;
        logic        carry_in;
    } sru_in_t;

    typedef struct packed {
        logic [15:0] result;
        logic        carry_out;
    } sru_out_t;

    // decoded item: rotates carry a left-rotate amount already reduced
    // to the ring size, shifts carry the masked count
    typedef struct packed {
        logic [2:0]  mode;
        logic        byte_width;
        logic [15:0] value;
        logic [4:0]  amount;
        logic        carry_in;
        logic        noop;
    } sru_work_t;

    // n mod 9 for n in 0..31
    function automatic logic [4:0] mod9(input logic [4:0] n);
        logic [4:0] r;
        if (n < 5'd9)
            r = n;
        else if (n < 5'd18)
            r = n - 5'd9;
        else if (n < 5'd27)
            r = n - 5'd18;
        else
            r = n - 5'd27;
        return r;
    endfunction

    // n mod 17 for n in 0..31
    function automatic logic [4:0] mod17(input logic [4:0] n);
        logic [4:0] r;
        if (n < 5'd17)
            r = n;
        else
            r = n - 5'd17;
        return r;
    endfunction

endpackage

>>> rtl/core/sru_front.sv
// ============================================================================
// sru_front - input stage of the shift and rotate unit
// Accepts input beats, masks the count and reduces rotate amounts.
// ============================================================================
module sru_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sru_pkg::sru_in_t   in_data,
    output logic               push_valid,
    input  logic               push_ready,
    output sru_pkg::sru_work_t push_data
);
    import sru_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    sru_work_t work_reg;
    sru_work_t work_next;
    logic      in_fire;

    logic [4:0] n;
    logic [4:0] m_ring;
    logic [4:0] ring_len;
    logic [4:0] neg_n;

    assign in_ready   = !valid_reg || push_ready;
    assign in_fire    = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_data  = work_reg;

    always_comb
    begin
        n        = in_data.shift_count[4:0] & CNT_MASK;
        neg_n    = 5'd0 - n;
        m_ring   = in_data.byte_width ? mod9(n) : mod17(n);
        ring_len = in_data.byte_width ? 5'd9 : 5'd17;

        work_next.mode       = in_data.mode;
        work_next.byte_width = in_data.byte_width;
        work_next.value      = in_data.byte_width ? {8'h00, in_data.value[7:0]}
                                                  : in_data.value;
        work_next.carry_in   = in_data.carry_in;
        work_next.noop       = (n == 5'd0) || (in_data.mode > OP_SAR);

        case (in_data.mode)
            OP_ROL:
                work_next.amount = in_data.byte_width ? {2'b00, n[2:0]} : {1'b0, n[3:0]};
            OP_ROR:
                work_next.amount = in_data.byte_width ? {2'b00, neg_n[2:0]}
                                                      : {1'b0, neg_n[3:0]};
            OP_RCL:
                work_next.amount = m_ring;
            OP_RCR:
                work_next.amount = (m_ring == 5'd0) ? 5'd0 : ring_len - m_ring;
            default:
                work_next.amount = n;
        endcase

        valid_next = in_fire || (valid_reg && !push_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            work_reg <= work_next;
    end

endmodule

>>> rtl/core/sru_queue.sv
// ============================================================================
// sru_queue - short FIFO between decode and execute
// Register-based queue; full/empty from an occupancy count.
// ============================================================================
module sru_queue #(
    parameter int DEPTH = sru_pkg::SRU_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  sru_pkg::sru_work_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output sru_pkg::sru_work_t pop_data
);
    import sru_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    sru_work_t           slots_reg [DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg, count_next;
    logic                push, pop;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    // occupancy tracking
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("queue count above depth");

    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not rise on push");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not fall on pop");

endmodule

>>> rtl/core/sru_back.sv
// ============================================================================
// sru_back - execute stage of the shift and rotate unit
// Barrel rotate/shift network followed by the output register.
// ============================================================================
module sru_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  sru_pkg::sru_work_t pop_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sru_pkg::sru_out_t  out_data
);
    import sru_pkg::*;

    logic     out_valid_reg, out_valid_next;
    sru_out_t out_reg, out_next;
    logic     pop;

    logic [31:0] dbl16;
    logic [15:0] dbl8;
    logic [33:0] dbl17;
    logic [17:0] dbl9;
    logic [47:0] shl_t;
    logic [16:0] shr_t;
    logic [31:0] sext;
    logic [32:0] sar_t;
    logic [15:0] res;
    logic        cf;
    logic [15:0] v;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        v     = pop_data.value;
        dbl16 = {v, v} << pop_data.amount[3:0];
        dbl8  = {v[7:0], v[7:0]} << pop_data.amount[2:0];
        dbl17 = {pop_data.carry_in, v, pop_data.carry_in, v} << pop_data.amount;
        dbl9  = {pop_data.carry_in, v[7:0], pop_data.carry_in, v[7:0]} << pop_data.amount;
        shl_t = {32'h0, v} << pop_data.amount;
        shr_t = {v, pop_data.carry_in} >> pop_data.amount;
        sext  = pop_data.byte_width ? {{24{v[7]}}, v[7:0]} : {{16{v[15]}}, v};
        sar_t = $signed({sext, pop_data.carry_in}) >>> pop_data.amount;

        res = v;
        cf  = pop_data.carry_in;
        if (!pop_data.noop)
        begin
            case (pop_data.mode)
                OP_ROL:
                begin
                    res = pop_data.byte_width ? {8'h00, dbl8[15:8]} : dbl16[31:16];
                    cf  = res[0];
                end
                OP_ROR:
                begin
                    res = pop_data.byte_width ? {8'h00, dbl8[15:8]} : dbl16[31:16];
                    cf  = pop_data.byte_width ? res[7] : res[15];
                end
                OP_RCL, OP_RCR:
                begin
                    res = pop_data.byte_width ? {8'h00, dbl9[16:9]} : dbl17[32:17];
                    cf  = pop_data.byte_width ? dbl9[17] : dbl17[33];
                end
                OP_SHL:
                begin
                    res = shl_t[15:0];
                    cf  = pop_data.byte_width ? shl_t[8] : shl_t[16];
                end
                OP_SHR:
                begin
                    res = shr_t[16:1];
                    cf  = shr_t[0];
                end
                OP_SAR:
                begin
                    res = sar_t[16:1];
                    cf  = sar_t[0];
                end
                default:
                begin
                    res = v;
                    cf  = pop_data.carry_in;
                end
            endcase
        end

        out_next.result    = pop_data.byte_width ? {8'h00, res[7:0]} : res;
        out_next.carry_out = cf;

        out_valid_next = pop || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= out_next;
    end

    // pass-through items leave value and carry untouched
    a_noop_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_data.noop) |=>
            (out_reg.result == $past(pop_data.value) &&
             out_reg.carry_out == $past(pop_data.carry_in)))
        else $error("no-op item altered value or carry");

endmodule

>>> rtl/core/shift_rotate_unit_8_16_unit.sv
// ============================================================================
// shift_rotate_unit_8_16_unit - 8/16-bit shift and rotate execute unit
// ROL, ROR, RCL, RCR, SHL/SAL, SHR and SAR on byte or word operands.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready/in_data): one beat per operation, with
//   mode, byte_width, value, shift_count and carry_in. Only the low five
//   count bits matter. Output channel (out_valid/out_ready/out_data): one
//   beat per input beat, in order, with result and carry_out.
//   From input accept to out_valid a beat passes the decode register,
//   queue slot and output register. Throughput is one beat per cycle while
//   out_ready is high; the barrel network is combinational, nothing iterates.
//   Decode (front) and execute (back) are split by a QUEUE_DEPTH-entry
//   queue. When the receiver stalls, the output register holds its beat,
//   the queue absorbs the beats in flight, and in_ready drops only once the
//   queue and decode register are both full.
//   Byte mode ignores the upper input byte and returns it as zero. A masked
//   count of zero, or mode code 7, passes value and carry through.
//   Reset (rst_n low, asynchronous) empties decode, queue and output
//   stages; the unit holds no other state.
// ============================================================================
module shift_rotate_unit_8_16_unit #(
    parameter int QUEUE_DEPTH = sru_pkg::SRU_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sru_pkg::sru_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sru_pkg::sru_out_t out_data
);
    import sru_pkg::*;

    // decode -> queue
    logic      push_valid;
    logic      push_ready;
    sru_work_t push_data;

    // queue -> execute
    logic      pop_valid;
    logic      pop_ready;
    sru_work_t pop_data;

    // front: masks the count, turns every rotate into a left rotate by an
    // amount reduced to the ring size (8, 9, 16 or 17 bits)
    sru_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decouples decode from the execute stage
    sru_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: barrel network plus output register
    sru_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
